// ===== rtl/core/q51dq_pkg.sv =====
// Package for the q5_1 block dequantiser: widths, special constants and the
// leading-zero count used by the normalise stage. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package q51dq_pkg;

  localparam int BlockElements = 32;
  localparam int PosW          = $clog2(BlockElements);
  localparam int SumW          = 46;
  localparam int LzW           = 6;
  localparam int InDataW       = 192;
  localparam int OutDataW      = 40;

  localparam logic [31:0] QnanDefault = 32'hFFC0_0000;

  // Decoded binary16 operand: value is sig * 2^(exp - 25).
  typedef struct packed {
    logic        sgn;
    logic [10:0] sig;
    logic [4:0]  exp;
    logic        is_inf;
    logic        is_nan;
    logic [9:0]  man;
  } half_dec_t;

  function automatic half_dec_t half_decode(input logic [15:0] h);
    half_dec_t d;
    d.sgn    = h[15];
    d.man    = h[9:0];
    d.sig    = {(h[14:10] != 5'd0), h[9:0]};
    d.exp    = (h[14:10] == 5'd0) ? 5'd1 : h[14:10];
    d.is_inf = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
    d.is_nan = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    return d;
  endfunction

  function automatic logic [LzW-1:0] lead_zeros(input logic [SumW-1:0] v);
    logic [LzW-1:0] n;
    logic           found;
    n     = LzW'(SumW);
    found = 1'b0;
    for (int i = SumW - 1; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = LzW'(SumW - 1 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/q5_1_block_dequantizer_core.sv =====
// q5_1 block dequantiser: one block in, 32 binary32 elements out.
// Depends on q51dq_pkg.
//
//  Channel  Dir  Transfer per      Fields
//  s_axis   in   block             tdata: scale, min, high bits, 16 nibble bytes; tlast: end of row
//  m_axis   out  element           tdata: value, element index; tlast: last in block; tuser: row done
//
// Each block occupies the element issue slot until its 32 elements are issued; the next block is
// taken in the cycle its final element is issued, so blocks follow back to back.
// An element leaves through a six-stage pipeline.
// rst clears the block buffer flag and all stage valid bits.
// A stall on m_axis holds every stage; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module q5_1_block_dequantizer_core import q51dq_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  // scale[15:0], min[31:16], high_bits[63:32], nibbles_lower[127:64],
  // nibbles_upper[191:128]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  input  wire logic                s_axis_tlast,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // value[31:0], element_index[36:32], zero fill [39:37]
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast,
  // row_done[0]
  output logic                     m_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready
);

  // Block buffer
  logic [15:0]     held_scale, held_minimum;
  logic [31:0]     held_high_bits;
  logic [127:0]    held_nibbles;
  logic            held_eor;
  logic            busy;
  logic [PosW-1:0] pos;

  logic advance, issue, accept, pos_last;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign issue         = busy && advance;
  assign pos_last      = (pos == PosW'(BlockElements - 1));
  assign s_axis_tready = !busy || (advance && pos_last);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else begin
      if (issue) begin
        pos <= pos + 1'b1;
        if (pos_last) busy <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
        pos  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_scale     <= s_axis_tdata[15:0];
      held_minimum   <= s_axis_tdata[31:16];
      held_high_bits <= s_axis_tdata[63:32];
      held_nibbles   <= s_axis_tdata[191:64];
      held_eor       <= s_axis_tlast;
    end
  end

  // Issue: code select and special-value resolution
  half_dec_t sc, mn;
  logic [7:0] byte_sel;
  logic [4:0] q;
  logic       spec;
  logic [31:0] spec_val;

  assign sc       = half_decode(held_scale);
  assign mn       = half_decode(held_minimum);
  assign byte_sel = held_nibbles[{pos[3:0], 3'b000} +: 8];
  assign q        = {held_high_bits[pos], (pos[4] ? byte_sel[7:4] : byte_sel[3:0])};

  always_comb begin
    spec     = 1'b1;
    spec_val = 32'd0;
    if (sc.is_nan) begin
      spec_val = {sc.sgn, 8'hFF, 1'b1, sc.man[8:0], 13'd0};
    end else if (sc.is_inf && q == 5'd0) begin
      spec_val = QnanDefault;
    end else if (mn.is_nan) begin
      spec_val = {mn.sgn, 8'hFF, 1'b1, mn.man[8:0], 13'd0};
    end else if (sc.is_inf && mn.is_inf && sc.sgn != mn.sgn) begin
      spec_val = QnanDefault;
    end else if (sc.is_inf) begin
      spec_val = {sc.sgn, 8'hFF, 23'd0};
    end else if (mn.is_inf) begin
      spec_val = {mn.sgn, 8'hFF, 23'd0};
    end else begin
      spec = 1'b0;
    end
  end

  // Stage valid bits and side data carried with each element
  logic            v1, v2, v3, v4, v5;
  logic [PosW-1:0] idx1, idx2, idx3, idx4, idx5;
  logic            lst1, lst2, lst3, lst4, lst5;
  logic            rd1, rd2, rd3, rd4, rd5;
  logic            sp1, sp2, sp3, sp4, sp5;
  logic [31:0]     spv1, spv2, spv3, spv4, spv5;

  // Stage 1 payload
  logic [4:0]  q1;
  half_dec_t   sc1, mn1;
  // Stage 2: aligned magnitudes on a common exponent
  logic [SumW-2:0] a2, b2;
  logic [4:0]      e2;
  logic            ps2, ms2;
  // Stage 3: signed sum
  logic [SumW-1:0] s3;
  logic [4:0]      e3;
  logic            sg3;
  // Stage 4: leading-zero count
  logic [SumW-1:0] s4;
  logic [4:0]      e4;
  logic            sg4;
  logic [LzW-1:0]  lz4;
  // Stage 5: normalised significand
  logic [SumW-1:0] n5;
  logic [7:0]      be5;
  logic            sg5, z5;

  logic [15:0]     prod;
  logic            es_ge;
  logic [4:0]      ediff;
  logic [SumW-1:0] a_ext, b_ext;
  logic            rnd_up;
  logic [30:0]     mag;

  assign prod  = 16'(q1) * 16'(sc1.sig);
  assign es_ge = (sc1.exp >= mn1.exp);
  assign ediff = es_ge ? (sc1.exp - mn1.exp) : (mn1.exp - sc1.exp);
  assign a_ext = {1'b0, a2};
  assign b_ext = {1'b0, b2};
  assign rnd_up = n5[21] && ((|n5[20:0]) || n5[22]);
  assign mag    = {be5, n5[44:22]} + 31'(rnd_up);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      v1 <= issue; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      m_axis_tvalid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      idx1 <= pos;  lst1 <= pos_last; rd1 <= pos_last && held_eor;
      sp1  <= spec; spv1 <= spec_val;
      q1   <= q;    sc1  <= sc;       mn1 <= mn;

      idx2 <= idx1; lst2 <= lst1; rd2 <= rd1; sp2 <= sp1; spv2 <= spv1;
      ps2  <= sc1.sgn;
      ms2  <= mn1.sgn;
      if (es_ge) begin
        a2 <= (45'(prod)) << ediff;
        b2 <= 45'(mn1.sig);
        e2 <= mn1.exp;
      end else begin
        a2 <= 45'(prod);
        b2 <= (45'(mn1.sig)) << ediff;
        e2 <= sc1.exp;
      end

      idx3 <= idx2; lst3 <= lst2; rd3 <= rd2; sp3 <= sp2; spv3 <= spv2;
      e3   <= e2;
      if (ps2 == ms2) begin
        s3  <= a_ext + b_ext;
        sg3 <= ps2;
      end else if (a2 >= b2) begin
        s3  <= a_ext - b_ext;
        sg3 <= (a2 == b2) ? (ps2 & ms2) : ps2;
      end else begin
        s3  <= b_ext - a_ext;
        sg3 <= ms2;
      end

      idx4 <= idx3; lst4 <= lst3; rd4 <= rd3; sp4 <= sp3; spv4 <= spv3;
      s4   <= s3;   e4   <= e3;   sg4 <= sg3;
      lz4  <= lead_zeros(s3);

      idx5 <= idx4; lst5 <= lst4; rd5 <= rd4; sp5 <= sp4; spv5 <= spv4;
      n5   <= s4 << lz4;
      // Biased exponent of the leading one: e + 147 - lz.
      be5  <= 8'(e4) + 8'd147 - 8'(lz4);
      sg5  <= sg4;
      z5   <= (s4 == '0);

      // Exact zero keeps the sign settled in the add stage.
      if (sp5)     m_axis_tdata[31:0] <= spv5;
      else if (z5) m_axis_tdata[31:0] <= {sg5, 31'd0};
      else         m_axis_tdata[31:0] <= {sg5, mag};
      m_axis_tdata[OutDataW-1:32] <= {3'd0, idx5};
      m_axis_tlast <= lst5;
      m_axis_tuser <= rd5;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && busy) |-> (pos_last && advance))
    else $error("block taken while the buffer still had elements to issue");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy && pos == '0))
    else $error("accepted block did not start at element zero");

  a_issue_holds: assert property (@(posedge clk) disable iff (rst)
    (issue && !pos_last && !accept) |=> busy)
    else $error("buffer released before its final element");

  a_row_done_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("row done flagged away from the final element");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for q5_1_block_dequantizer_core: blocks go in on s_axis,
// each is predicted into 32 binary32 elements and checked against m_axis.
// Depends on q51dq_pkg and the core; reads no files.
`timescale 1ns / 1ps

module testbench import q51dq_pkg::*; ();

  localparam logic [31:0] QuietBit = 32'h0040_0000;

  typedef struct {
    logic [15:0] scale;
    logic [15:0] minimum;
    logic [31:0] high_bits;
    logic [63:0] nib_lo;
    logic [63:0] nib_hi;
    logic        end_of_row;
  } block_t;

  typedef struct {
    logic [31:0] value;
    logic [4:0]  index;
    logic        last;
    logic        row_done;
  } element_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;

  element_t pending_elements[$];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       recv_hold_cycles = 0;
  int       fail_count = 0;
  int       blocks_sent = 0;
  int       elements_seen = 0;

  q5_1_block_dequantizer_core DUT (
    .clk(clk), .rst(rst),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Binary16 NaN or infinity to binary32, exact; only used for NaN results here.
  function automatic logic [31:0] widen_half(input logic [15:0] h);
    return {h[15], 8'hFF, h[9:0], 13'd0};
  endfunction

  // Magnitude of a finite half in units of 2^-24.
  function automatic logic [63:0] half_units(input logic [15:0] h);
    logic [63:0] sig;
    sig = {53'd0, (h[14:10] != 5'd0), h[9:0]};
    return (h[14:10] == 5'd0) ? sig : sig << (h[14:10] - 5'd1);
  endfunction

  function automatic logic [31:0] dequantise(input logic [4:0] q, input logic [15:0] sc,
                                             input logic [15:0] mn);
    logic        sc_nan, sc_inf, mn_nan, mn_inf, psgn, sgn;
    longint      ps, ms, s;
    logic [63:0] a, mant, rem, halfway;
    int          k, ex, sh;
    sc_nan = (sc[14:10] == 5'h1F) && (sc[9:0] != 0);
    sc_inf = (sc[14:10] == 5'h1F) && (sc[9:0] == 0);
    mn_nan = (mn[14:10] == 5'h1F) && (mn[9:0] != 0);
    mn_inf = (mn[14:10] == 5'h1F) && (mn[9:0] == 0);
    psgn   = sc[15];
    if (sc_nan) return widen_half(sc) | QuietBit;
    if (sc_inf && q == 5'd0) return QnanDefault;
    if (mn_nan) return widen_half(mn) | QuietBit;
    if (sc_inf) begin
      if (mn_inf && mn[15] != psgn) return QnanDefault;
      return {psgn, 8'hFF, 23'd0};
    end
    if (mn_inf) return {mn[15], 8'hFF, 23'd0};
    // Both operands are now exact multiples of 2^-24, so the sum is exact here.
    ps = longint'(q) * longint'(half_units(sc));
    if (psgn) ps = -ps;
    ms = longint'(half_units(mn));
    if (mn[15]) ms = -ms;
    s = ps + ms;
    if (s == 0) return {psgn & mn[15], 31'd0};
    sgn = (s < 0);
    a = sgn ? 64'(-s) : 64'(s);
    k = 0;
    for (int i = 0; i < 64; i++) if (a[i]) k = i;
    ex = k + 103;
    if (k <= 23) begin
      mant = a << (23 - k);
    end else begin
      sh = k - 23;
      mant = a >> sh;
      rem = a & ((64'd1 << sh) - 1);
      halfway = 64'd1 << (sh - 1);
      if (rem > halfway || (rem == halfway && mant[0])) mant = mant + 1;
      if (mant[24]) begin
        mant = mant >> 1;
        ex = ex + 1;
      end
    end
    return {sgn, ex[7:0], mant[22:0]};
  endfunction

  task automatic expect_block(input block_t b);
    element_t    e;
    logic [63:0] word;
    logic [7:0]  byte_val;
    logic [3:0]  nib;
    for (int n = 0; n < BlockElements; n++) begin
      word = ((n % 16) < 8) ? b.nib_lo : b.nib_hi;
      byte_val = word[(n % 8) * 8 +: 8];
      nib = (n < 16) ? byte_val[3:0] : byte_val[7:4];
      e.value = dequantise({b.high_bits[n], nib}, b.scale, b.minimum);
      e.index = 5'(n);
      e.last = (n == BlockElements - 1);
      e.row_done = e.last & b.end_of_row;
      pending_elements.push_back(e);
    end
  endtask

  task automatic send_block(input block_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b.nib_hi, b.nib_lo, b.high_bits, b.minimum, b.scale};
    s_axis_tlast <= b.end_of_row;
    // Ready is read mid-cycle, well clear of the edge that makes the transfer.
    do begin
      @(negedge clk);
    end while (!s_axis_tready);
    @(posedge clk);
    expect_block(b);
    blocks_sent++;
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_elements.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_half();
    case ($urandom_range(9))
      0: return {1'($urandom), 15'd0};
      1: return {1'($urandom), 5'h1F, 10'd0};
      2: return {1'($urandom), 5'h1F, 10'($urandom_range(1, 1023))};
      3: return {1'($urandom), 5'd0, 10'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic block_t random_block();
    block_t b;
    b.scale = pick_half();
    b.minimum = pick_half();
    b.high_bits = $urandom;
    b.nib_lo = {$urandom, $urandom};
    b.nib_hi = {$urandom, $urandom};
    b.end_of_row = 1'($urandom);
    return b;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (recv_hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      recv_hold_cycles <= recv_hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    element_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      elements_seen++;
      if (pending_elements.size() == 0) begin
        $error("unexpected element: value %h index %0d", m_axis_tdata[31:0],
               m_axis_tdata[36:32]);
        fail_count++;
      end else begin
        e = pending_elements.pop_front();
        if (m_axis_tdata[31:0] !== e.value) begin
          $error("value: expected %h, got %h", e.value, m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tdata[36:32] !== e.index) begin
          $error("element_index: expected %0d, got %0d", e.index, m_axis_tdata[36:32]);
          fail_count++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last_in_block: expected %b, got %b", e.last, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser !== e.row_done) begin
          $error("row_done: expected %b, got %b", e.row_done, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    block_t b;
    logic [15:0] sc_list[14] = '{16'h3C00, 16'hFFFF, 16'h0000, 16'h7E01, 16'h7C00,
                                 16'h3C00, 16'h7C00, 16'h8000, 16'h0001, 16'h7BFF,
                                 16'h7BFF, 16'h7C01, 16'hFC00, 16'hBC00};
    logic [15:0] mn_list[14] = '{16'h0000, 16'hFFFF, 16'h0000, 16'h3C00, 16'h3C00,
                                 16'hFD55, 16'hFC00, 16'h8000, 16'h83FF, 16'hFBFF,
                                 16'h0001, 16'h0000, 16'hFC00, 16'h7C00};
    for (int i = 0; i < 14; i++) begin
      b.scale = sc_list[i];
      b.minimum = mn_list[i];
      b.high_bits = (i % 3 == 0) ? 32'hAAAA_5555 : (i % 3 == 1) ? 32'hFFFF_FFFF : 32'h0;
      // Else byte j has nibbles j and (j+8) mod 16; each half sees every nibble.
      b.nib_lo = (i == 1) ? '1 : (i == 2) ? '0 : 64'hF7E6_D5C4_B3A2_9180;
      b.nib_hi = (i == 1) ? '1 : (i == 2) ? '0 : 64'h7F6E_5D4C_3B2A_1908;
      b.end_of_row = i[0];
      send_block(b);
    end
    wait_drained();
  endtask

  task automatic test_random(input int count, input int s_idle, input int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (count) send_block(random_block());
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_cycles = 400;
    repeat (10) send_block(random_block());
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(110, 29, 86);
    test_random(110, 86, 29);
    test_backpressure();
    test_random(120, 0, 0);
    repeat (20) @(posedge clk);
    $display("Covered %0d blocks and %0d elements: special halves, stalls on both sides,",
             blocks_sent, elements_seen);
    $display("a long output hold-off and full-rate streaming.");
    if (fail_count == 0 && pending_elements.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
